// File: rtl/drmap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drmap_pkg
// Shared widths, codes and control types for the dual rate moving average.
// ----------------------------------------------------------------------------
package drmap_pkg;

  localparam int SAMPLE_W       = 31;
  localparam int WIN_W          = 4;
  localparam int PM_W           = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_WINDOW_DEF = 10;
  localparam int PERMILLE       = 1000;
  localparam int PERMILLE_W     = 10;
  localparam int WINDOW_RST     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 2'd2;

  localparam logic [PM_W-1:0] PM_SAT = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_DROP,
    ST_STORE,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_RATE_IN,
    OP_RATE_OUT,
    OP_PM_IN,
    OP_PM_OUT,
    OP_PM_TOT
  } div_op_t;

  typedef struct packed {
    logic    latch_item;
    logic    rd_oldest;
    logic    drop;
    logic    store;
    logic    div_start;
    logic    div_capture;
    div_op_t div_op;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic div_done;
  } dp_sts_t;

endpackage

// File: rtl/drmap_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drmap_if
// Sample, result and configuration channels (valid/ready transfer).
// ----------------------------------------------------------------------------
interface drmap_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [drmap_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, output req_type, output sample_value, input ready);
  modport sink (input valid, input req_type, input sample_value, output ready);
endinterface

interface drmap_out_if;
  logic                          valid;
  logic                          ready;
  logic [drmap_pkg::SAMPLE_W-1:0] in_rate;
  logic [drmap_pkg::SAMPLE_W-1:0] out_rate;
  logic [drmap_pkg::PM_W-1:0]     in_permille;
  logic [drmap_pkg::PM_W-1:0]     out_permille;
  logic [drmap_pkg::PM_W-1:0]     total_permille;

  modport source (output valid, output in_rate, output out_rate, output in_permille,
                  output out_permille, output total_permille, input ready);
  modport sink (input valid, input in_rate, input out_rate, input in_permille,
                input out_permille, input total_permille, output ready);
endinterface

interface drmap_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [drmap_pkg::CFG_IDX_W-1:0] index;
  logic [drmap_pkg::SAMPLE_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/dual_rate_moving_average_permille.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_rate_moving_average_permille
// Receive/transmit moving averages of rate samples with permille readouts.
// ----------------------------------------------------------------------------
// Each sample transfer on in_ch updates the receive (req_type 0) or transmit
// (req_type 1) window and yields exactly one result transfer on out_ch: both
// mean rates and their permille of in_max, out_max and their sum, saturated at
// 65535. The result is offered, and the next sample can be taken, only once
// the old samples that no longer fit are dropped (usually 0 or 1), the sample is
// stored and the single shared serial divider, max(31 + clog2(MAX_WINDOW+1),
// 42) bits wide, has worked out all five quotients at one quotient bit per
// cycle. A finished result waits in an output register, so the next sample is
// taken while it is still pending; a result still waiting when the next one is
// ready stalls that one.
// cfg is always ready; write it only while idle.
module dual_rate_moving_average_permille #(
  parameter int MAX_WINDOW = drmap_pkg::MAX_WINDOW_DEF
) (
  input logic         clk,
  input logic         rst,
  drmap_in_if.sink    in_ch,
  drmap_out_if.source out_ch,
  drmap_cfg_if.sink   cfg
);

  drmap_pkg::dp_cmd_t cmd;
  drmap_pkg::dp_sts_t sts;

  assign cfg.ready = 1'b1;

  drmap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  drmap_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_type       (in_ch.req_type),
    .sample_value   (in_ch.sample_value),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .in_rate        (out_ch.in_rate),
    .out_rate       (out_ch.out_rate),
    .in_permille    (out_ch.in_permille),
    .out_permille   (out_ch.out_permille),
    .total_permille (out_ch.total_permille)
  );

endmodule

// File: rtl/drmap_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drmap_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module drmap_div #(
  parameter int DVD_W = 42,
  parameter int DVS_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem, quotient[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CNT_W'(1));
      if (start && !running) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DVD_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !running) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (running) begin
      if (!diff[DVS_W]) begin
        rem      <= diff[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        rem      <= trial[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/drmap_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drmap_dp
// Datapath: sample stores, running sums, divider operands, result registers.
// ----------------------------------------------------------------------------
module drmap_dp #(
  parameter int MAX_WINDOW = drmap_pkg::MAX_WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  drmap_pkg::dp_cmd_t               cmd,
  output drmap_pkg::dp_sts_t               sts,
  input  logic                             req_type,
  input  logic [drmap_pkg::SAMPLE_W-1:0]   sample_value,
  input  logic                             cfg_we,
  input  logic [drmap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drmap_pkg::SAMPLE_W-1:0]   cfg_data,
  output logic [drmap_pkg::SAMPLE_W-1:0]   in_rate,
  output logic [drmap_pkg::SAMPLE_W-1:0]   out_rate,
  output logic [drmap_pkg::PM_W-1:0]       in_permille,
  output logic [drmap_pkg::PM_W-1:0]       out_permille,
  output logic [drmap_pkg::PM_W-1:0]       total_permille
);

  localparam int SW        = drmap_pkg::SAMPLE_W;
  localparam int IDX_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W     = SW + CNT_W;
  localparam int CMP_W     = (CNT_W > drmap_pkg::WIN_W) ? CNT_W : drmap_pkg::WIN_W;
  localparam int PM_NUM_W  = SW + 1 + drmap_pkg::PERMILLE_W;
  localparam int DVD_W     = (SUM_W > PM_NUM_W) ? SUM_W : PM_NUM_W;
  localparam int DVS_W     = SW + 1;
  localparam int MEM_D     = 2 << IDX_W;

  // configuration
  logic [drmap_pkg::WIN_W-1:0] window_size;
  logic [SW-1:0]               in_max;
  logic [SW-1:0]               out_max;

  // channel state, index 0 receive, 1 transmit
  logic [CNT_W-1:0] count  [2];
  logic [IDX_W-1:0] oldest [2];
  logic [SUM_W-1:0] sum    [2];
  logic [SW-1:0]    mem    [MEM_D];

  logic          chan;
  logic [SW-1:0] sample;
  logic [SW-1:0] rdata;
  logic          den_zero;

  logic [SW-1:0]                res_in_rate;
  logic [SW-1:0]                res_out_rate;
  logic [drmap_pkg::PM_W-1:0]   res_in_pm;
  logic [drmap_pkg::PM_W-1:0]   res_out_pm;
  logic [drmap_pkg::PM_W-1:0]   res_tot_pm;

  logic [CMP_W-1:0] eff_win;
  logic [CNT_W:0]   slot_sum;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] oldest_inc;
  logic [DVS_W-1:0] pm_num;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic             div_done;
  logic [DVD_W-1:0] quotient;
  logic [DVD_W-1:0] q_res;
  logic [drmap_pkg::PM_W-1:0] q_sat;

  // effective window: 0 acts as 1, clipped to MAX_WINDOW
  always_comb begin
    if (window_size == '0) begin
      eff_win = CMP_W'(1);
    end else if (CMP_W'(window_size) > CMP_W'(MAX_WINDOW)) begin
      eff_win = CMP_W'(MAX_WINDOW);
    end else begin
      eff_win = CMP_W'(window_size);
    end
  end

  assign sts.full = CMP_W'(count[chan]) >= eff_win;

  always_comb begin
    slot_sum = (CNT_W + 1)'(oldest[chan]) + (CNT_W + 1)'(count[chan]);
    if (slot_sum >= (CNT_W + 1)'(MAX_WINDOW)) begin
      slot_sum = slot_sum - (CNT_W + 1)'(MAX_WINDOW);
    end
    slot = slot_sum[IDX_W-1:0];
  end

  assign oldest_inc = (oldest[chan] == IDX_W'(MAX_WINDOW - 1)) ? '0
                                                              : oldest[chan] + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= drmap_pkg::WIN_W'(drmap_pkg::WINDOW_RST);
      in_max      <= '0;
      out_max     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        drmap_pkg::CFG_WINDOW:  window_size <= cfg_data[drmap_pkg::WIN_W-1:0];
        drmap_pkg::CFG_IN_MAX:  in_max      <= cfg_data;
        drmap_pkg::CFG_OUT_MAX: out_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      chan   <= req_type;
      sample <= sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        count[i]  <= '0;
        oldest[i] <= '0;
        sum[i]    <= '0;
      end
    end else if (cmd.drop) begin
      sum[chan]    <= sum[chan] - SUM_W'(rdata);
      oldest[chan] <= oldest_inc;
      count[chan]  <= count[chan] - CNT_W'(1);
    end else if (cmd.store) begin
      sum[chan]   <= sum[chan] + SUM_W'(sample);
      count[chan] <= count[chan] + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[{chan, slot}] <= sample;
    end
    if (cmd.rd_oldest) begin
      rdata <= mem[{chan, oldest[chan]}];
    end
  end

  // divider operands
  always_comb begin
    pm_num = '0;
    dvd    = '0;
    dvs    = '0;
    case (cmd.div_op)
      drmap_pkg::OP_RATE_IN: begin
        dvd = DVD_W'(sum[0]);
        dvs = DVS_W'(count[0]);
      end
      drmap_pkg::OP_RATE_OUT: begin
        dvd = DVD_W'(sum[1]);
        dvs = DVS_W'(count[1]);
      end
      drmap_pkg::OP_PM_IN: begin
        pm_num = DVS_W'(res_in_rate);
        dvs    = DVS_W'(in_max);
      end
      drmap_pkg::OP_PM_OUT: begin
        pm_num = DVS_W'(res_out_rate);
        dvs    = DVS_W'(out_max);
      end
      drmap_pkg::OP_PM_TOT: begin
        pm_num = DVS_W'(res_in_rate) + DVS_W'(res_out_rate);
        dvs    = DVS_W'(in_max) + DVS_W'(out_max);
      end
      default: ;
    endcase
    if (cmd.div_op != drmap_pkg::OP_RATE_IN && cmd.div_op != drmap_pkg::OP_RATE_OUT) begin
      dvd = DVD_W'(PM_NUM_W'(pm_num) * PM_NUM_W'(drmap_pkg::PERMILLE));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      den_zero <= (dvs == '0);
    end
  end

  drmap_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quotient)
  );

  assign sts.div_done = div_done;

  assign q_res = den_zero ? '0 : quotient;
  assign q_sat = (q_res[DVD_W-1:drmap_pkg::PM_W] != '0) ? drmap_pkg::PM_SAT
                                                         : q_res[drmap_pkg::PM_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_capture) begin
      case (cmd.div_op)
        drmap_pkg::OP_RATE_IN:  res_in_rate  <= q_res[SW-1:0];
        drmap_pkg::OP_RATE_OUT: res_out_rate <= q_res[SW-1:0];
        drmap_pkg::OP_PM_IN:    res_in_pm    <= q_sat;
        drmap_pkg::OP_PM_OUT:   res_out_pm   <= q_sat;
        drmap_pkg::OP_PM_TOT:   res_tot_pm   <= q_sat;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      in_rate        <= res_in_rate;
      out_rate       <= res_out_rate;
      in_permille    <= res_in_pm;
      out_permille   <= res_out_pm;
      total_permille <= res_tot_pm;
    end
  end

endmodule

// File: rtl/drmap_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drmap_ctrl
// Controller: window trimming, sample store, division sequence, output handoff.
// ----------------------------------------------------------------------------
module drmap_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output drmap_pkg::dp_cmd_t cmd,
  input  drmap_pkg::dp_sts_t sts
);

  drmap_pkg::state_t  state;
  drmap_pkg::state_t  state_next;
  drmap_pkg::div_op_t op;
  drmap_pkg::div_op_t op_next;
  logic               out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= drmap_pkg::ST_IDLE;
      op        <= drmap_pkg::OP_RATE_IN;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.div_op     = op;

    case (state)
      drmap_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = drmap_pkg::ST_CHECK;
        end
      end
      drmap_pkg::ST_CHECK: begin
        state_next = sts.full ? drmap_pkg::ST_READ : drmap_pkg::ST_STORE;
      end
      drmap_pkg::ST_READ: begin
        cmd.rd_oldest = 1'b1;
        state_next    = drmap_pkg::ST_DROP;
      end
      drmap_pkg::ST_DROP: begin
        cmd.drop   = 1'b1;
        state_next = drmap_pkg::ST_CHECK;
      end
      drmap_pkg::ST_STORE: begin
        cmd.store  = 1'b1;
        op_next    = drmap_pkg::OP_RATE_IN;
        state_next = drmap_pkg::ST_DIV_START;
      end
      drmap_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = drmap_pkg::ST_DIV_RUN;
      end
      drmap_pkg::ST_DIV_RUN: begin
        if (sts.div_done) begin
          cmd.div_capture = 1'b1;
          state_next      = drmap_pkg::ST_DIV_START;
          case (op)
            drmap_pkg::OP_RATE_IN:  op_next = drmap_pkg::OP_RATE_OUT;
            drmap_pkg::OP_RATE_OUT: op_next = drmap_pkg::OP_PM_IN;
            drmap_pkg::OP_PM_IN:    op_next = drmap_pkg::OP_PM_OUT;
            drmap_pkg::OP_PM_OUT:   op_next = drmap_pkg::OP_PM_TOT;
            default:                state_next = drmap_pkg::ST_FINISH;
          endcase
        end
      end
      drmap_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = drmap_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = drmap_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: verif/drmap_rate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drmap_rate_checker
// Watches the sample, result and register channels of the dual rate moving
// average block. It tracks both sample windows and the register values, works
// out the rates and permille figures that each sample transfer should give,
// and compares every result transfer with the oldest outstanding one.
// ----------------------------------------------------------------------------
module drmap_rate_checker #(
  parameter int MAX_WINDOW = drmap_pkg::MAX_WINDOW_DEF
) (
  input  logic  clk,
  input  logic  rst,
  drmap_in_if   in_ch,
  drmap_out_if  out_ch,
  drmap_cfg_if  cfg,
  output int    failures,
  output int    outstanding
);
  import drmap_pkg::*;

  typedef struct packed {
    bit [SAMPLE_W-1:0] in_rate;
    bit [SAMPLE_W-1:0] out_rate;
    bit [PM_W-1:0]     in_permille;
    bit [PM_W-1:0]     out_permille;
    bit [PM_W-1:0]     total_permille;
  } rate_result_t;

  bit [WIN_W-1:0]    window_reg;
  bit [SAMPLE_W-1:0] in_max_reg;
  bit [SAMPLE_W-1:0] out_max_reg;

  // per channel: index 0 receive, index 1 transmit
  bit [SAMPLE_W-1:0] win_buf [2][MAX_WINDOW];
  int                win_head [2];
  int                win_fill [2];
  bit [63:0]         win_sum [2];

  rate_result_t      expected_rates [$];
  rate_result_t      want;

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
  endtask

  function automatic void add_sample(input bit chan, input bit [SAMPLE_W-1:0] value);
    int w;
    w = window_reg;
    if (w < 1) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    while (win_fill[chan] >= w) begin
      win_sum[chan] -= 64'(win_buf[chan][win_head[chan]]);
      win_head[chan] = (win_head[chan] + 1) % MAX_WINDOW;
      win_fill[chan]--;
    end
    win_buf[chan][(win_head[chan] + win_fill[chan]) % MAX_WINDOW] = value;
    win_sum[chan] += 64'(value);
    win_fill[chan]++;
  endfunction

  function automatic bit [63:0] channel_mean(input bit chan);
    if (win_fill[chan] == 0) return 64'd0;
    return win_sum[chan] / 64'(win_fill[chan]);
  endfunction

  function automatic bit [PM_W-1:0] permille_of(input bit [63:0] num, input bit [63:0] den);
    bit [63:0] q;
    if (den == 64'd0) return '0;
    q = num * 64'(PERMILLE) / den;
    return (q > 64'(PM_SAT)) ? PM_SAT : q[PM_W-1:0];
  endfunction

  function automatic rate_result_t predict_rates();
    rate_result_t r;
    bit [63:0]    ri;
    bit [63:0]    ro;
    ri = channel_mean(1'b0);
    ro = channel_mean(1'b1);
    r.in_rate        = ri[SAMPLE_W-1:0];
    r.out_rate       = ro[SAMPLE_W-1:0];
    r.in_permille    = permille_of(ri, 64'(in_max_reg));
    r.out_permille   = permille_of(ro, 64'(out_max_reg));
    r.total_permille = permille_of(ri + ro, 64'(in_max_reg) + 64'(out_max_reg));
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      window_reg  = WIN_W'(WINDOW_RST);
      in_max_reg  = '0;
      out_max_reg = '0;
      win_head    = '{0, 0};
      win_fill    = '{0, 0};
      win_sum     = '{64'd0, 64'd0};
      failures    = 0;
      expected_rates.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rates.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          want = expected_rates.pop_front();
          check_field("in_rate", 64'(out_ch.in_rate), 64'(want.in_rate));
          check_field("out_rate", 64'(out_ch.out_rate), 64'(want.out_rate));
          check_field("in_permille", 64'(out_ch.in_permille), 64'(want.in_permille));
          check_field("out_permille", 64'(out_ch.out_permille), 64'(want.out_permille));
          check_field("total_permille", 64'(out_ch.total_permille),
                      64'(want.total_permille));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_WINDOW:  window_reg  = cfg.data[WIN_W-1:0];
          CFG_IN_MAX:  in_max_reg  = cfg.data;
          CFG_OUT_MAX: out_max_reg = cfg.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        add_sample(in_ch.req_type, in_ch.sample_value);
        expected_rates.push_back(predict_rates());
      end
    end
    outstanding <= expected_rates.size();
  end

endmodule

// File: verif/dual_rate_moving_average_permille_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_rate_moving_average_permille_test
// Drives rate samples and register writes into the dual rate moving average
// block: a directed pass over window limits, zero and full-scale maxima and
// saturation, then randomised phases with fresh register settings. Both the
// sample and result sides idle at random; a separate checker does the scoring.
// ----------------------------------------------------------------------------
module dual_rate_moving_average_permille_test;
  import drmap_pkg::*;

  localparam bit                   SRC_RX   = 1'b0;
  localparam bit                   SRC_TX   = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  localparam bit [SAMPLE_W-1:0]    FULL     = '1;
  localparam int                   PHASES   = 12;
  localparam int                   PER_PHASE = 160;

  logic clk = 1'b0;
  logic rst;
  int   failures;
  int   outstanding;
  bit   no_idle = 1'b0;
  bit [SAMPLE_W-1:0] rx_ceiling;
  bit [SAMPLE_W-1:0] tx_ceiling;

  drmap_in_if  in_ch ();
  drmap_out_if out_ch ();
  drmap_cfg_if cfg_ch ();

  dual_rate_moving_average_permille u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  drmap_rate_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg         (cfg_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  task automatic send_sample(input bit src, input bit [SAMPLE_W-1:0] value);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= src;
    in_ch.sample_value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // leaves valid high; caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [SAMPLE_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic program_regs(input bit [WIN_W-1:0] win, input bit [SAMPLE_W-1:0] rx_max,
                              input bit [SAMPLE_W-1:0] tx_max);
    write_reg(CFG_WINDOW, SAMPLE_W'(win));
    write_reg(CFG_IN_MAX, rx_max);
    write_reg(CFG_OUT_MAX, tx_max);
    cfg_ch.valid <= 1'b0;
    rx_ceiling = rx_max;
    tx_ceiling = tx_max;
  endtask

  // wait until every sample transfer has had its result
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic bit [SAMPLE_W-1:0] pick_ceiling();
    bit [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return r[SAMPLE_W-1:0];
      2:       return SAMPLE_W'($urandom_range(1, 5000));
      default: return FULL;
    endcase
  endfunction

  function automatic bit [SAMPLE_W-1:0] pick_sample(input bit [SAMPLE_W-1:0] ceiling);
    bit [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0, 1:    return r[SAMPLE_W-1:0];
      2:       return r[0] ? FULL : '0;
      default: begin
        // around the configured maximum, so permille stays mostly unsaturated
        if (ceiling == '0) return SAMPLE_W'($urandom_range(0, 2000));
        r = $urandom_range(0, {ceiling, 1'b0});
        return r[31] ? FULL : r[SAMPLE_W-1:0];
      end
    endcase
  endfunction

  initial begin : result_sink
    int unsigned hold;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin : stimulus
    bit src;
    rst                <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= 1'b0;
    in_ch.sample_value <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_WINDOW;
    cfg_ch.data        <= '0;
    rx_ceiling = '0;
    tx_ceiling = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: window of three, both maxima zero
    send_sample(SRC_RX, '0);
    send_sample(SRC_RX, FULL);
    send_sample(SRC_TX, FULL);
    send_sample(SRC_TX, '0);
    send_sample(SRC_RX, FULL);
    send_sample(SRC_RX, FULL);
    send_sample(SRC_RX, FULL);

    // tiny maxima: every permille saturates
    settle();
    program_regs(4'd10, 31'd1, 31'd1);
    send_sample(SRC_TX, FULL);
    send_sample(SRC_TX, FULL);
    send_sample(SRC_RX, 31'd1);

    // window zero behaves as one; full-scale maxima
    settle();
    program_regs(4'd0, FULL, FULL);
    send_sample(SRC_RX, FULL);
    send_sample(SRC_TX, 31'd12345);

    // oversize window clamps to the maximum
    settle();
    program_regs(4'd15, 31'd1000, 31'd3000);
    send_sample(SRC_RX, 31'd100);
    send_sample(SRC_RX, 31'd200);
    send_sample(SRC_RX, 31'd300);
    send_sample(SRC_RX, 31'd400);
    send_sample(SRC_RX, 31'd500);

    // shrink: receive mean keeps all samples until its next transfer
    settle();
    program_regs(4'd2, 31'd1000, 31'd3000);
    send_sample(SRC_TX, 31'd777);
    send_sample(SRC_RX, 31'd600);

    // unused register index must change nothing
    settle();
    write_reg(CFG_NONE, FULL);
    cfg_ch.valid <= 1'b0;
    send_sample(SRC_RX, 31'd50);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      no_idle = (phase % 4 == 3);
      program_regs(WIN_W'($urandom_range(0, 15)), pick_ceiling(), pick_ceiling());
      for (int n = 0; n < PER_PHASE; n++) begin
        src = $urandom_range(0, 1);
        send_sample(src, pick_sample(src ? tx_ceiling : rx_ceiling));
      end
    end
    no_idle = 1'b0;

    settle();
    repeat (300) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
rtl/drmap_pkg.sv
rtl/drmap_if.sv
rtl/drmap_div.sv
rtl/drmap_dp.sv
rtl/drmap_ctrl.sv
rtl/dual_rate_moving_average_permille.sv
verif/drmap_rate_checker.sv
verif/dual_rate_moving_average_permille_test.sv
